/* sv/maze_route_distance_table_assert.svh */
// Assertion macros shared by the distance table modules.
// Bodies use the clk and rst names of the module that expands them.
`ifndef MAZE_ROUTE_DISTANCE_TABLE_ASSERT_SVH
`define MAZE_ROUTE_DISTANCE_TABLE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define MRDT_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define MRDT_ASSERT_AFTER(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mrdt_pkg.sv */
// Types and constants of the maze distance table: request and result
// payloads, control word between sequencer and datapath, codes. No dependencies.
package mrdt_pkg;

  localparam int CELL_W     = 8;
  localparam int DIST_W     = 32;
  localparam int WEIGHT_W   = 8;
  localparam int CELL_SLOTS = 256;
  localparam int GOAL_SLOTS = 4;

  localparam logic [DIST_W-1:0] DIST_UNREACHED = '1;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_BEST  = 2'd2,
    MODE_PRED  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_GOAL0       = 3'd0,
    REG_GOAL1       = 3'd1,
    REG_GOAL2       = 3'd2,
    REG_GOAL3       = 3'd3,
    REG_GOAL_COUNT  = 3'd4,
    REG_TURN_WEIGHT = 3'd5,
    REG_START_CELL  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CELL_W-1:0] from_cell;
    logic [1:0]        from_heading;
    logic [CELL_W-1:0] to_cell;
    logic [1:0]        to_heading;
  } item_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_res;
    logic [DIST_W-1:0] distance;
    logic              found;
    logic              at_start;
  } item_out_t;

  // one table entry: predecessor flag and cell, distance
  typedef struct packed {
    logic              pvalid;
    logic [CELL_W-1:0] pcell;
    logic [DIST_W-1:0] dval;
  } entry_t;

  typedef enum logic [1:0] {
    ADDR_FROM,
    ADDR_TO,
    ADDR_GOAL,
    ADDR_PRED
  } addr_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED,
    OP_LATCH_SRC,
    OP_CAND,
    OP_RELAX,
    OP_GOAL_CMP,
    OP_LATCH_PRED,
    OP_RES_TO,
    OP_RES_BEST,
    OP_RES_PRED
  } op_t;

  typedef struct packed {
    op_t       op;
    addr_sel_t asel;
    logic      rd;
    logic      emit;
    logic      fire;
  } ctrl_t;

  typedef struct packed {
    logic goals_done;
    logic out_busy;
  } stat_t;

endpackage

/* sv/maze_route_distance_table.sv */
// Distance and predecessor table for a grid robot. One request runs at a time
// under a small microcode program; a new request is taken as soon as the
// previous one has placed its result in the output register, even if that
// result has not been taken yet. A clear seeds and reads back the target; a
// move reads source and target, then relaxes; a predecessor query reads the
// target, then its predecessor; a best goal query compares each checked goal.
// Each table lookup costs one program step: the single table RAM has a
// registered read. A clear takes effect at once through per-entry valid bits,
// so reset needs no sweep. Uses mrdt_pkg, mrdt_seq, mrdt_dp and mrdt_ram.
module maze_route_distance_table #(
  parameter int GRID_SIDE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  mrdt_pkg::item_in_t  req,
  output logic                res_valid,
  input  logic                res_ready,
  output mrdt_pkg::item_out_t res,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [7:0]          cfg_wdata
);
  import mrdt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  assign accept = req_valid && req_ready;

  mrdt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .mode      (req.mode),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mrdt_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .accept    (accept),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

/* sv/mrdt_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
module mrdt_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mrdt_seq.sv */
// Microcode sequencer: step counter, control ROM, mode dispatch and jumps.
// Uses mrdt_pkg and the assertion macro header.
`include "maze_route_distance_table_assert.svh"

module mrdt_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [1:0]     mode,
  output logic           req_ready,
  input  mrdt_pkg::stat_t stat,
  output mrdt_pkg::ctrl_t ctrl
);
  import mrdt_pkg::*;

  typedef logic [3:0] step_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_JUMP_GDONE,
    SEQ_END
  } seq_op_t;

  typedef struct packed {
    seq_op_t   seq;
    step_t     target;
    addr_sel_t asel;
    logic      rd;
    op_t       op;
    logic      emit;
  } ucode_t;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_CLR      = 4'd1;
  localparam step_t S_CLR_RD   = 4'd2;
  localparam step_t S_CLR_RES  = 4'd3;
  localparam step_t S_MV       = 4'd4;
  localparam step_t S_MV_TO    = 4'd5;
  localparam step_t S_MV_CAND  = 4'd6;
  localparam step_t S_MV_RES   = 4'd7;
  localparam step_t S_BG       = 4'd8;
  localparam step_t S_BG_CMP   = 4'd9;
  localparam step_t S_BG_RES   = 4'd10;
  localparam step_t S_PQ       = 4'd11;
  localparam step_t S_PQ_PRED  = 4'd12;
  localparam step_t S_PQ_RES   = 4'd13;

  function automatic ucode_t ucode(input step_t s);
    ucode_t u;
    u = '{seq: SEQ_NEXT, target: S_IDLE, asel: ADDR_TO, rd: 1'b0,
          op: OP_NONE, emit: 1'b0};
    case (s)
      S_CLR:     u.op = OP_SEED;
      S_CLR_RD:  u.rd = 1'b1;
      S_CLR_RES: begin
        u.op = OP_RES_TO; u.emit = 1'b1; u.seq = SEQ_END;
      end
      S_MV: begin
        u.asel = ADDR_FROM; u.rd = 1'b1;
      end
      S_MV_TO: begin
        u.op = OP_LATCH_SRC; u.rd = 1'b1;
      end
      S_MV_CAND: u.op = OP_CAND;
      S_MV_RES: begin
        u.op = OP_RELAX; u.emit = 1'b1; u.seq = SEQ_END;
      end
      S_BG: begin
        u.asel = ADDR_GOAL; u.rd = 1'b1;
        u.seq = SEQ_JUMP_GDONE; u.target = S_BG_RES;
      end
      S_BG_CMP: begin
        u.op = OP_GOAL_CMP; u.seq = SEQ_JUMP; u.target = S_BG;
      end
      S_BG_RES: begin
        u.op = OP_RES_BEST; u.emit = 1'b1; u.seq = SEQ_END;
      end
      S_PQ:      u.rd = 1'b1;
      S_PQ_PRED: begin
        u.op = OP_LATCH_PRED; u.asel = ADDR_PRED; u.rd = 1'b1;
      end
      S_PQ_RES: begin
        u.op = OP_RES_PRED; u.emit = 1'b1; u.seq = SEQ_END;
      end
      default:   u.seq = SEQ_END;
    endcase
    return u;
  endfunction

  function automatic step_t entry_step(input logic [1:0] m);
    step_t s;
    case (m)
      MODE_CLEAR: s = S_CLR;
      MODE_MOVE:  s = S_MV;
      MODE_BEST:  s = S_BG;
      MODE_PRED:  s = S_PQ;
      default:    s = S_IDLE;
    endcase
    return s;
  endfunction

  step_t  step;
  step_t  step_next;
  ucode_t uw;
  logic   accept;
  logic   stall;

  assign uw        = ucode(step);
  assign req_ready = (step == S_IDLE);
  assign accept    = req_valid && req_ready;
  // a result step waits while the output register is still full
  assign stall     = uw.emit && stat.out_busy;

  assign ctrl.op   = uw.op;
  assign ctrl.asel = uw.asel;
  assign ctrl.rd   = uw.rd;
  assign ctrl.emit = uw.emit;
  assign ctrl.fire = (step != S_IDLE) && !stall;

  always_comb begin
    step_next = step;
    if (step == S_IDLE) begin
      if (accept) begin
        step_next = entry_step(mode);
      end
    end else if (!stall) begin
      case (uw.seq)
        SEQ_NEXT:       step_next = step + 4'd1;
        SEQ_JUMP:       step_next = uw.target;
        SEQ_JUMP_GDONE: step_next = stat.goals_done ? uw.target : step + 4'd1;
        SEQ_END:        step_next = S_IDLE;
        default:        step_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  `MRDT_ASSERT_HOLDS(a_idle_quiet, step == S_IDLE, !ctrl.fire, "datapath fired while idle")
  `MRDT_ASSERT_AFTER(a_stall_holds, stall, step == $past(step), "step moved during stall")
  `MRDT_ASSERT_AFTER(a_dispatch, accept, step == S_CLR || step == S_MV || step == S_BG || step == S_PQ, "bad dispatch")

endmodule

/* sv/mrdt_dp.sv */
// Datapath: config registers, table RAM with per-entry valid bits, work
// registers and the output register. Uses mrdt_pkg, mrdt_ram, assertion macros.
`include "maze_route_distance_table_assert.svh"

module mrdt_dp #(
  parameter int GRID_SIDE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mrdt_pkg::ctrl_t     ctrl,
  output mrdt_pkg::stat_t     stat,
  input  logic                accept,
  input  mrdt_pkg::item_in_t  req,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [7:0]          cfg_wdata,
  output logic                res_valid,
  input  logic                res_ready,
  output mrdt_pkg::item_out_t res
);
  import mrdt_pkg::*;

  localparam logic [CELL_W:0] GRID_CELLS = (CELL_W+1)'(GRID_SIDE * GRID_SIDE);

  function automatic logic in_grid(input logic [CELL_W-1:0] c);
    return {1'b0, c} < GRID_CELLS;
  endfunction

  // configuration
  logic [CELL_W-1:0]   goal_addr [GOAL_SLOTS];
  logic [2:0]          goal_count;
  logic [WEIGHT_W-1:0] turn_weight;
  logic [CELL_W-1:0]   home_cell;

  // table and its valid bits; an entry without its bit reads as unreached
  logic [CELL_SLOTS-1:0] vld;
  entry_t                rdata;
  entry_t                wdata;
  logic                  we;
  logic                  re;
  logic [CELL_W-1:0]     raddr;
  logic [CELL_W-1:0]     waddr;
  logic                  rd_vld;

  logic [DIST_W-1:0]     ent_dist;
  logic                  ent_pvalid;

  // work registers
  item_in_t            req_q;
  logic                mv_ok;
  logic [WEIGHT_W-1:0] run_weight;
  logic [DIST_W-1:0]   src_dist;
  logic [DIST_W-1:0]   cand;
  logic [DIST_W-1:0]   to_dist;
  logic                to_pvalid;
  logic [CELL_W:0]     pred_q;
  logic [2:0]          gidx;
  logic [DIST_W-1:0]   best;
  logic [CELL_W-1:0]   best_cell;
  logic                have;

  logic [CELL_W-1:0]   goal_sel;
  logic [2:0]          goal_lim;
  logic [WEIGHT_W-1:0] step_w;
  logic [DIST_W:0]     sum;
  logic [DIST_W-1:0]   cand_next;
  logic                relax_hit;
  logic                load;
  item_out_t           res_next;

  mrdt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CELL_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ent_dist   = rd_vld ? rdata.dval : DIST_UNREACHED;
  assign ent_pvalid = rd_vld && rdata.pvalid;

  assign goal_sel = goal_addr[gidx[1:0]];
  assign goal_lim = (goal_count > 3'(GOAL_SLOTS)) ? 3'(GOAL_SLOTS) : goal_count;

  assign stat.goals_done = (gidx >= goal_lim);
  assign stat.out_busy   = res_valid && !res_ready;

  always_comb begin
    case (ctrl.asel)
      ADDR_FROM: raddr = req_q.from_cell;
      ADDR_TO:   raddr = req_q.to_cell;
      ADDR_GOAL: raddr = goal_sel;
      ADDR_PRED: raddr = rdata.pcell;
      default:   raddr = req_q.to_cell;
    endcase
  end
  assign re = ctrl.fire && ctrl.rd;

  // step cost and saturating sum
  assign step_w    = (req_q.from_heading != req_q.to_heading) ? turn_weight : run_weight;
  assign sum       = {1'b0, src_dist} + (DIST_W+1)'(step_w);
  assign cand_next = sum[DIST_W] ? DIST_UNREACHED : sum[DIST_W-1:0];
  assign relax_hit = mv_ok && (to_dist > cand);

  always_comb begin
    we    = 1'b0;
    waddr = req_q.to_cell;
    wdata = '{pvalid: 1'b1, pcell: req_q.from_cell, dval: cand};
    if (ctrl.fire && ctrl.op == OP_SEED) begin
      we    = in_grid(req_q.to_cell);
      wdata = '{pvalid: 1'b0, pcell: '0, dval: DIST_W'(turn_weight)};
    end else if (ctrl.fire && ctrl.op == OP_RELAX) begin
      we    = relax_hit;
    end
  end

  always_comb begin
    res_next = '{cell_res: '0, distance: DIST_UNREACHED, found: 1'b0, at_start: 1'b0};
    case (ctrl.op)
      OP_RES_TO: begin
        res_next.cell_res = req_q.to_cell;
        res_next.distance = ent_dist;
        res_next.found    = ent_pvalid;
      end
      OP_RELAX: begin
        res_next.cell_res = req_q.to_cell;
        res_next.distance = relax_hit ? cand : to_dist;
        res_next.found    = relax_hit || to_pvalid;
      end
      OP_RES_BEST: begin
        if (have) begin
          res_next.cell_res = best_cell;
          res_next.distance = best;
          res_next.found    = 1'b1;
        end
      end
      OP_RES_PRED: begin
        if (pred_q[CELL_W]) begin
          res_next.cell_res = pred_q[CELL_W-1:0];
          res_next.distance = ent_dist;
          res_next.found    = 1'b1;
        end
      end
      default: ;
    endcase
    res_next.at_start = res_next.found && (res_next.cell_res == home_cell);
  end

  assign load = ctrl.fire && ctrl.emit;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_addr[0] <= 8'd119;
      goal_addr[1] <= 8'd120;
      goal_addr[2] <= 8'd135;
      goal_addr[3] <= 8'd136;
      goal_count   <= 3'd4;
      turn_weight  <= 8'd32;
      home_cell    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GOAL0:       goal_addr[0] <= cfg_wdata;
        REG_GOAL1:       goal_addr[1] <= cfg_wdata;
        REG_GOAL2:       goal_addr[2] <= cfg_wdata;
        REG_GOAL3:       goal_addr[3] <= cfg_wdata;
        REG_GOAL_COUNT:  goal_count   <= cfg_wdata[2:0];
        REG_TURN_WEIGHT: turn_weight  <= cfg_wdata;
        REG_START_CELL:  home_cell    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      rd_vld     <= 1'b0;
      run_weight <= 8'd32;
      gidx       <= '0;
      have       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (ctrl.fire && ctrl.op == OP_SEED) begin
        // a clear keeps only the seeded entry
        vld <= we ? (CELL_SLOTS'(1) << waddr) : '0;
      end else if (we) begin
        vld[waddr] <= 1'b1;
      end

      if (re) begin
        rd_vld <= vld[raddr] && in_grid(raddr);
      end

      // run weight moves only on a move inside the grid
      if (ctrl.fire && ctrl.op == OP_CAND && mv_ok) begin
        if (req_q.from_heading != req_q.to_heading) begin
          run_weight <= turn_weight;
        end else if (run_weight != '0) begin
          run_weight <= run_weight - 8'd1;
        end
      end

      if (accept) begin
        gidx <= '0;
        have <= 1'b0;
      end else if (ctrl.fire && ctrl.op == OP_GOAL_CMP) begin
        gidx <= gidx + 3'd1;
        if (ent_dist < best) begin
          have <= 1'b1;
        end
      end

      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      mv_ok <= in_grid(req.from_cell) && in_grid(req.to_cell);
      best  <= DIST_UNREACHED;
    end
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_LATCH_SRC:  src_dist <= ent_dist;
        OP_CAND: begin
          cand      <= cand_next;
          to_dist   <= ent_dist;
          to_pvalid <= ent_pvalid;
        end
        OP_GOAL_CMP: begin
          if (ent_dist < best) begin
            best      <= ent_dist;
            best_cell <= goal_sel;
          end
        end
        OP_LATCH_PRED: pred_q <= {ent_pvalid, rdata.pcell};
        default: ;
      endcase
    end
    if (load) begin
      res <= res_next;
    end
  end

  `MRDT_ASSERT_HOLDS(a_write_ops, we, ctrl.op == OP_SEED || ctrl.op == OP_RELAX, "table write outside seed or relax")
  `MRDT_ASSERT_HOLDS(a_goal_bound, 1'b1, gidx <= 3'(GOAL_SLOTS), "goal index past last goal")
  `MRDT_ASSERT_AFTER(a_clear_one, ctrl.fire && ctrl.op == OP_SEED, $countones(vld) <= 1, "clear left stale entries")

endmodule

/* tb/maze_route_distance_table_test.sv */
// Self-checking bench for maze_route_distance_table: random and directed requests
// are checked against a predictor of the distance and predecessor tables.
// Depends on mrdt_pkg and the maze_route_distance_table RTL.
module maze_route_distance_table_test;
  import mrdt_pkg::*;

  class route_scoreboard;
    int                cell_count;
    logic [7:0]        goal_c [GOAL_SLOTS];
    logic [2:0]        goal_n;
    logic [7:0]        turn_w;
    logic [7:0]        start_c;
    logic [7:0]        run_w;
    logic [DIST_W-1:0] dist_tab [CELL_SLOTS];
    logic [8:0]        pred_tab [CELL_SLOTS];
    item_out_t         expected_q [$];
    int                errors;

    function new(int side);
      cell_count = side * side;
      goal_c     = '{8'd119, 8'd120, 8'd135, 8'd136};
      goal_n     = 3'd4;
      turn_w     = 8'd32;
      start_c    = 8'd0;
      run_w      = turn_w;
      errors     = 0;
      foreach (dist_tab[i]) begin
        dist_tab[i] = DIST_UNREACHED;
        pred_tab[i] = '0;
      end
    endfunction

    function bit on_grid(logic [7:0] c);
      return int'(c) < cell_count;
    endfunction

    function logic [DIST_W-1:0] dist_at(logic [7:0] c);
      return on_grid(c) ? dist_tab[c] : DIST_UNREACHED;
    endfunction

    function logic [8:0] pred_at(logic [7:0] c);
      return on_grid(c) ? pred_tab[c] : 9'd0;
    endfunction

    function logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] a, logic [7:0] w);
      logic [DIST_W:0] s;
      s = {1'b0, a} + {25'd0, w};
      return s[DIST_W] ? DIST_UNREACHED : s[DIST_W-1:0];
    endfunction

    function item_out_t make_res(logic [7:0] c, logic [DIST_W-1:0] d, logic f);
      item_out_t o;
      o.cell_res = c;
      o.distance = d;
      o.found    = f;
      o.at_start = f && (c == start_c);
      return o;
    endfunction

    function void write_reg(reg_idx_t idx, logic [7:0] val);
      case (idx)
        REG_GOAL0:       goal_c[0] = val;
        REG_GOAL1:       goal_c[1] = val;
        REG_GOAL2:       goal_c[2] = val;
        REG_GOAL3:       goal_c[3] = val;
        REG_GOAL_COUNT:  goal_n = val[2:0];
        REG_TURN_WEIGHT: turn_w = val;
        REG_START_CELL:  start_c = val;
        default: ;
      endcase
    endfunction

    // apply one accepted request to the tables and queue its result
    function void note_request(item_in_t r);
      logic [DIST_W-1:0] cand;
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] best_d;
      logic [7:0]        best_c;
      logic [8:0]        p;
      logic              have;
      int                n;
      case (mode_t'(r.mode))
        MODE_CLEAR: begin
          foreach (dist_tab[i]) begin
            dist_tab[i] = DIST_UNREACHED;
            pred_tab[i] = '0;
          end
          if (on_grid(r.to_cell))
            dist_tab[r.to_cell] = {24'd0, turn_w};
        end
        MODE_MOVE: begin
          if (on_grid(r.from_cell) && on_grid(r.to_cell)) begin
            if (r.from_heading != r.to_heading) begin
              cand  = sat_sum(dist_tab[r.from_cell], turn_w);
              run_w = turn_w;
            end else begin
              cand = sat_sum(dist_tab[r.from_cell], run_w);
              if (run_w != 8'd0)
                run_w = run_w - 8'd1;
            end
            if (dist_tab[r.to_cell] > cand) begin
              dist_tab[r.to_cell] = cand;
              pred_tab[r.to_cell] = {1'b1, r.from_cell};
            end
          end
        end
        MODE_BEST: begin
          n      = (goal_n > GOAL_SLOTS) ? GOAL_SLOTS : int'(goal_n);
          best_d = DIST_UNREACHED;
          best_c = '0;
          have   = 1'b0;
          for (int i = 0; i < n; i++) begin
            d = dist_at(goal_c[i]);
            // strictly smaller only: the first goal wins a tie
            if (d < best_d) begin
              best_d = d;
              best_c = goal_c[i];
              have   = 1'b1;
            end
          end
          if (have)
            expected_q.push_back(make_res(best_c, best_d, 1'b1));
          else
            expected_q.push_back(make_res(8'd0, DIST_UNREACHED, 1'b0));
        end
        default: begin
          p = pred_at(r.to_cell);
          if (p[8])
            expected_q.push_back(make_res(p[7:0], dist_at(p[7:0]), 1'b1));
          else
            expected_q.push_back(make_res(8'd0, DIST_UNREACHED, 1'b0));
        end
      endcase
      if (r.mode == MODE_CLEAR || r.mode == MODE_MOVE) begin
        p = pred_at(r.to_cell);
        expected_q.push_back(make_res(r.to_cell, dist_at(r.to_cell), p[8]));
      end
    endfunction

    function void report(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(item_out_t got);
      item_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: cell %0h distance %0h found %b at_start %b",
                 $time, got.cell_res, got.distance, got.found, got.at_start);
      end else begin
        want = expected_q.pop_front();
        if (got.cell_res !== want.cell_res)
          report("cell_res", DIST_W'(want.cell_res), DIST_W'(got.cell_res));
        if (got.distance !== want.distance)
          report("distance", want.distance, got.distance);
        if (got.found !== want.found)
          report("found", DIST_W'(want.found), DIST_W'(got.found));
        if (got.at_start !== want.at_start)
          report("at_start", DIST_W'(want.at_start), DIST_W'(got.at_start));
      end
    endfunction
  endclass

  localparam int GRID_SIDE   = 16;
  localparam int ITEM_TARGET = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;

  localparam logic [1:0] NORTH = 2'd0;
  localparam logic [1:0] EAST  = 2'd1;
  localparam logic [1:0] SOUTH = 2'd2;
  localparam logic [1:0] WEST  = 2'd3;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  item_in_t   req       = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  item_out_t  res;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_idx   = '0;
  logic [7:0] cfg_wdata = '0;

  route_scoreboard book;
  int n_sent = 0;
  int n_done = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 80;
  int stuck_cycles = 0;
  bit hold_off_due = 1'b0;

  maze_route_distance_table #(.GRID_SIDE(GRID_SIDE)) uut (
    .clk, .rst, .req_valid, .req_ready, .req, .res_valid, .res_ready, .res,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready)
      book.note_request(req);
    if (!rst && res_valid && res_ready) begin
      book.check_result(res);
      n_done++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("maze_route_distance_table_test NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // result side: random back-pressure, plus one long hold-off on demand
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] any_cell();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [1:0] any_heading();
    return 2'($urandom_range(3));
  endfunction

  function automatic item_in_t request_of(mode_t m, logic [7:0] fc, logic [1:0] fh,
                                          logic [7:0] tc, logic [1:0] th);
    item_in_t it;
    it.mode         = m;
    it.from_cell    = fc;
    it.from_heading = fh;
    it.to_cell      = tc;
    it.to_heading   = th;
    return it;
  endfunction

  task automatic send_request(input item_in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (n_done != n_sent) @(posedge clk);
  endtask

  task automatic write_one(input reg_idx_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    book.write_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [7:0] g0, input logic [7:0] g1,
                                input logic [7:0] g2, input logic [7:0] g3,
                                input logic [2:0] gn, input logic [7:0] tw,
                                input logic [7:0] sc);
    wait_drained();
    write_one(REG_GOAL0, g0);
    write_one(REG_GOAL1, g1);
    write_one(REG_GOAL2, g2);
    write_one(REG_GOAL3, g3);
    write_one(REG_GOAL_COUNT, {5'd0, gn});
    write_one(REG_TURN_WEIGHT, tw);
    write_one(REG_START_CELL, sc);
    cfg_we <= 1'b0;
  endtask

  // clear at a seed, then a random walk around it with queries and noise mixed in
  task automatic run_episode(input int walk_len, input bit stall_receiver);
    logic [7:0]  seed;
    logic [7:0]  cur;
    logic [7:0]  g [GOAL_SLOTS];
    logic [7:0]  trail [$];
    logic [7:0]  tw;
    logic [7:0]  sc;
    logic [2:0]  gn;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  nx;
    logic [3:0]  ny;
    logic [1:0]  hd;
    logic [1:0]  nhd;
    logic [1:0]  fhd;
    logic [31:0] noise;
    int          r;
    seed = any_cell();
    for (int i = 0; i < GOAL_SLOTS; i++) begin
      if ($urandom_range(99) < 20)
        g[i] = any_cell();
      else
        g[i] = {seed[7:4] + 4'($urandom_range(6)) - 4'd3,
                seed[3:0] + 4'($urandom_range(6)) - 4'd3};
    end
    r = $urandom_range(99);
    if (r < 8)       gn = 3'd0;
    else if (r < 16) gn = 3'($urandom_range(7, 5));
    else             gn = 3'($urandom_range(4, 1));
    r = $urandom_range(99);
    if (r < 10)      tw = 8'd255;
    else if (r < 20) tw = 8'd1;
    else if (r < 26) tw = 8'd0;
    else if (r < 50) tw = 8'($urandom_range(6, 2));
    else             tw = any_cell();
    sc = ($urandom_range(99) < 70) ? seed : any_cell();
    apply_settings(g[0], g[1], g[2], g[3], gn, tw, sc);

    send_request(request_of(MODE_CLEAR, any_cell(), any_heading(), seed, any_heading()));
    if (stall_receiver)
      hold_off_due = 1'b1;
    x  = seed[7:4];
    y  = seed[3:0];
    hd = any_heading();
    trail.push_back(seed);
    repeat (walk_len) begin
      r = $urandom_range(99);
      if (r < 6) begin
        noise = $urandom;
        send_request(noise[$bits(item_in_t)-1:0]);
      end else if (r < 14) begin
        send_request(request_of(MODE_PRED, any_cell(), any_heading(),
                                trail[$urandom_range(trail.size() - 1)],
                                any_heading()));
      end else if (r < 20) begin
        send_request(request_of(MODE_BEST, any_cell(), any_heading(),
                                any_cell(), any_heading()));
      end else begin
        // mostly straight runs so the run weight winds down
        nhd = ($urandom_range(99) < 65) ? hd : any_heading();
        fhd = ($urandom_range(99) < 8) ? any_heading() : hd;
        if ($urandom_range(99) < 6) begin
          cur = trail[$urandom_range(trail.size() - 1)];
          x   = cur[7:4];
          y   = cur[3:0];
        end
        cur = {x, y};
        nx  = x;
        ny  = y;
        case (nhd)
          NORTH:   ny = y + 4'd1;
          EAST:    nx = x + 4'd1;
          SOUTH:   ny = y - 4'd1;
          default: nx = x - 4'd1;
        endcase
        send_request(request_of(MODE_MOVE, cur, fhd, {nx, ny}, nhd));
        trail.push_back({nx, ny});
        x  = nx;
        y  = ny;
        hd = nhd;
      end
    end
  endtask

  initial begin
    book = new(GRID_SIDE);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: nothing reached yet, unreached source does nothing
    send_request(request_of(MODE_BEST, 8'd0, NORTH, 8'd0, NORTH));
    send_request(request_of(MODE_PRED, 8'd0, NORTH, 8'd119, NORTH));
    send_request(request_of(MODE_MOVE, 8'd5, EAST, 8'd6, EAST));
    send_request(request_of(MODE_CLEAR, 8'hFF, WEST, 8'd0, WEST));
    send_request(request_of(MODE_MOVE, 8'd0, NORTH, 8'd1, NORTH));
    send_request(request_of(MODE_MOVE, 8'd1, NORTH, 8'd2, NORTH));
    send_request(request_of(MODE_MOVE, 8'd2, NORTH, 8'd18, EAST));
    send_request(request_of(MODE_MOVE, 8'd18, EAST, 8'd18, EAST));
    send_request(request_of(MODE_MOVE, 8'd0, SOUTH, 8'd18, EAST));
    send_request(request_of(MODE_PRED, 8'd0, NORTH, 8'd18, NORTH));
    send_request(request_of(MODE_PRED, 8'd0, NORTH, 8'd2, NORTH));
    send_request(request_of(MODE_CLEAR, 8'd0, NORTH, 8'd119, NORTH));
    send_request(request_of(MODE_MOVE, 8'd119, WEST, 8'd120, WEST));
    send_request(request_of(MODE_MOVE, 8'd119, NORTH, 8'd135, EAST));
    send_request(request_of(MODE_BEST, 8'd0, NORTH, 8'd0, NORTH));
    send_request(request_of(MODE_CLEAR, 8'd0, NORTH, 8'hFF, NORTH));
    send_request(request_of(MODE_MOVE, 8'hFF, WEST, 8'h00, WEST));
    send_request(request_of(MODE_PRED, 8'hFF, WEST, 8'h00, WEST));

    // goal count above four, heaviest turn weight, trace ending at the top cell
    apply_settings(8'd120, 8'd119, 8'd136, 8'd135, 3'd7, 8'd255, 8'd255);
    send_request(request_of(MODE_CLEAR, 8'd0, NORTH, 8'd136, NORTH));
    send_request(request_of(MODE_MOVE, 8'd136, NORTH, 8'd120, EAST));
    send_request(request_of(MODE_BEST, 8'd0, NORTH, 8'd0, NORTH));
    send_request(request_of(MODE_MOVE, 8'd120, EAST, 8'd255, EAST));
    send_request(request_of(MODE_MOVE, 8'd255, EAST, 8'd254, EAST));
    send_request(request_of(MODE_PRED, 8'd0, NORTH, 8'd254, NORTH));

    // no goals checked, zero turn weight: run weight pinned at zero
    apply_settings(8'd0, 8'd1, 8'd2, 8'd3, 3'd0, 8'd0, 8'hAA);
    send_request(request_of(MODE_CLEAR, 8'd0, NORTH, 8'd0, NORTH));
    send_request(request_of(MODE_BEST, 8'd0, NORTH, 8'd0, NORTH));
    send_request(request_of(MODE_MOVE, 8'd0, NORTH, 8'd1, EAST));
    send_request(request_of(MODE_MOVE, 8'd1, EAST, 8'd2, EAST));

    run_episode(40, 1'b1);
    while (n_sent < ITEM_TARGET) begin
      if (n_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 27;
      end
      run_episode($urandom_range(45, 10), 1'b0);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (book.errors == 0 && book.expected_q.size() == 0)
      $display("maze_route_distance_table_test OK");
    else
      $display("maze_route_distance_table_test NOT OK");
    $finish;
  end
endmodule
